### sv/pcrs_pkg.sv
// Shared types, constants and tables for the peak compressor with ratio select.
package pcrs_pkg;

    localparam int CHANNELS = 2;
    localparam int ENV_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int SAMPLE_W   = 24;
    localparam int RED_W      = 14;
    localparam int GAIN_W     = 21;
    localparam int COEFF_W    = 24;
    localparam int SEL_W      = 3;
    localparam int ENV_W      = 32;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int OUT_DATA_W = 40;
    localparam int DIV_STEPS  = 30;

    localparam logic [GAIN_W-1:0]  INPUT_GAIN_RST    = 21'd57083;
    localparam logic [GAIN_W-1:0]  OUTPUT_GAIN_RST   = 21'd65536;
    localparam logic [COEFF_W-1:0] ATTACK_COEFF_RST  = 24'd75487;
    localparam logic [COEFF_W-1:0] RELEASE_COEFF_RST = 24'd874;
    localparam logic [SEL_W-1:0]   RATIO_SELECT_RST  = 3'd0;
    localparam logic               BYPASS_RST        = 1'b1;

    localparam logic [SEL_W-1:0] SEL_ALL = 3'd4;

    localparam logic [31:0] Q30_ONE    = 32'd1073741824;
    localparam logic [22:0] DB_SCALE   = 23'd6313057;
    localparam logic [23:0] DB_OFFSET  = 24'd6318457;
    localparam logic [21:0] RED_TO_EXP = 22'd2786635;
    localparam logic [22:0] K_ALL      = 23'd4387049;
    localparam logic [22:0] K_STD      = 23'd3479383;
    localparam logic [20:0] N_ALL      = 21'd1170687;
    localparam logic [20:0] N_STD      = 21'd1282264;
    localparam logic [13:0] RED_MAX    = 14'd16383;
    localparam logic [23:0] POS_MAX    = 24'd8388607;
    localparam logic [26:0] NEG_MAX    = 27'd8388608;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_GAIN    = 3'd0,
        CFG_OUTPUT_GAIN   = 3'd1,
        CFG_ATTACK_COEFF  = 3'd2,
        CFG_RELEASE_COEFF = 3'd3,
        CFG_RATIO_SELECT  = 3'd4,
        CFG_BYPASS        = 3'd5
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_X_MUL,
        ST_X_GET,
        ST_ENV_DIF,
        ST_ENV_MUL,
        ST_ENV_UPD,
        ST_NORM,
        ST_SQ,
        ST_DB_MUL,
        ST_DB_GET,
        ST_RED_MUL,
        ST_RED_GET,
        ST_GEXP_MUL,
        ST_GEXP_GET,
        ST_EXP,
        ST_EXP_END,
        ST_Y_MUL,
        ST_Y_GET,
        ST_A_MUL,
        ST_A_GET,
        ST_DIV,
        ST_T_MUL,
        ST_T_GET,
        ST_O_MUL,
        ST_O_GET,
        ST_DONE
    } state_t;

    typedef logic [23:0][29:0] root_tab_t;

    // ratio slope (1 - 1/ratio) in Q.16
    function automatic logic [15:0] ratio_factor(input logic [SEL_W-1:0] sel);
        logic [15:0] f;
        unique case (sel)
            3'd0:    f = 16'd49152;
            3'd1:    f = 16'd57344;
            3'd2:    f = 16'd60075;
            3'd3:    f = 16'd62259;
            default: f = 16'd63351;
        endcase
        return f;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bq;
        int          i;
        v   = v_in;
        res = '0;
        bq  = 64'h4000_0000_0000_0000;
        for (i = 0; i < 32; i++) begin
            if (v >= res + bq) begin
                v   = v - (res + bq);
                res = (res >> 1) + bq;
            end else begin
                res = res >> 1;
            end
            bq = bq >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-k) in Q0.30 for k = 1..24, by repeated square roots from 0.5
    function automatic root_tab_t build_roots();
        root_tab_t   r;
        logic [63:0] prev;
        int          k;
        prev = isqrt64(64'd1 << 59);
        r[0] = prev[29:0];
        for (k = 1; k < 24; k++) begin
            prev = isqrt64(prev << 30);
            r[k] = prev[29:0];
        end
        return r;
    endfunction

    localparam root_tab_t ROOT_TAB = build_roots();

endpackage

### sv/pcrs_mul.sv
// Shared 32 x 32 unsigned multiplier with a registered product.
module pcrs_mul
(
    input  logic                          clk,
    input  logic [pcrs_pkg::MUL_W-1:0]    a,
    input  logic [pcrs_pkg::MUL_W-1:0]    b,
    output logic [pcrs_pkg::PROD_W-1:0]   prod
);

    logic [pcrs_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= pcrs_pkg::PROD_W'(a) * pcrs_pkg::PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

### sv/pcrs_env_mem.sv
// Per-channel envelope memory with registered read and reset-cleared valid bits.
module pcrs_env_mem
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pcrs_pkg::ENV_AW-1:0]   rd_addr,
    output logic [pcrs_pkg::ENV_W-1:0]    rd_data,
    input  logic                          wr_en,
    input  logic [pcrs_pkg::ENV_AW-1:0]   wr_addr,
    input  logic [pcrs_pkg::ENV_W-1:0]    wr_data
);

    logic [pcrs_pkg::ENV_W-1:0]    mem [pcrs_pkg::CHANNELS];
    logic [pcrs_pkg::CHANNELS-1:0] valid_reg;
    logic [pcrs_pkg::ENV_W-1:0]    rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // an entry never written reads as zero
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/pcrs_div.sv
// Bit-serial divider forming tanh as (1 - q) / (1 + q) in Q0.30.
module pcrs_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [30:0] q,
    output logic        done,
    output logic [30:0] t
);

    logic        run_reg, run_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] den_reg, den_next;
    logic [31:0] rem_reg, rem_next;
    logic [30:0] quo_reg, quo_next;

    logic [31:0] den_in;
    logic [31:0] nhi;
    logic [32:0] rem2;
    logic        ge;

    assign den_in = pcrs_pkg::Q30_ONE + 32'(q);
    assign nhi    = pcrs_pkg::Q30_ONE - 32'(q);
    assign rem2   = {rem_reg, 1'b0};
    assign ge     = rem2 >= {1'b0, den_reg};

    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            // top quotient bit set only when q is zero
            den_next = den_in;
            rem_next = (nhi >= den_in) ? nhi - den_in : nhi;
            quo_next = {30'd0, nhi >= den_in};
            cnt_next = 5'(pcrs_pkg::DIV_STEPS);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (cnt_reg != 5'd0)
            begin
                rem_next = ge ? 32'(rem2 - {1'b0, den_reg}) : rem2[31:0];
                quo_next = {quo_reg[29:0], ge};
                cnt_next = cnt_reg - 5'd1;
            end
            else
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = run_reg && (cnt_reg == 5'd0);
    assign t    = quo_reg;

endmodule

### sv/peak_compressor_ratio_select.sv
// Top level: sequencer, configuration registers and output register of the compressor.
// Datapath: a bypassed word goes straight to the done state and the output register;
//   a processed word runs through the single shared multiplier (16 log squarings,
//   two 24-step exp2 chains that multiply only on set bits) and the 30-step divider.
// Throughput: one word at a time; the next word is accepted while a result waits.
// Reset (rst_n low, asynchronous): sequencer idle, output empty, registers at defaults,
//   envelope entries read as zero until written.
module peak_compressor_ratio_select
(
    input  logic                                clk,
    input  logic                                rst_n,
    // slave stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,    // [23:0] sample_in
    input  logic [0:0]                          s_tuser,    // [0] channel
    // master stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pcrs_pkg::OUT_DATA_W-1:0]     m_tdata,    // [23:0] sample_out,
                                                            // [37:24] reduction_db, [39:38] 0
    output logic [0:0]                          m_tuser,    // [0] channel_out
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcrs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // sequencer state and control
    pcrs_pkg::state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        ph_reg, ph_next;
    logic        exp_clip_reg, exp_clip_next;

    // configuration registers
    logic [20:0] ig_reg, ig_next;
    logic [20:0] og_reg, og_next;
    logic [23:0] atk_reg, atk_next;
    logic [23:0] rel_reg, rel_next;
    logic [2:0]  sel_reg, sel_next;
    logic        byp_reg, byp_next;

    // datapath
    logic        chan_reg, chan_next;
    logic        neg_reg, neg_next;
    logic [23:0] mag_reg, mag_next;
    logic [27:0] x_reg, x_next;
    logic [31:0] env_reg, env_next;
    logic [31:0] diff_reg, diff_next;
    logic        rise_reg, rise_next;
    logic [31:0] norm_reg, norm_next;
    logic [4:0]  shift_reg, shift_next;
    logic [4:0]  p_reg, p_next;
    logic [15:0] frac_reg, frac_next;
    logic [31:0] m_reg, m_next;
    logic [23:0] over_reg, over_next;
    logic [23:0] red_reg, red_next;
    logic [13:0] red_db_reg, red_db_next;
    logic [35:0] ea_reg, ea_next;
    logic [30:0] gain_reg, gain_next;
    logic [27:0] y_reg, y_next;
    logic [30:0] t_reg, t_next;
    logic [21:0] clip_reg, clip_next;
    logic [23:0] res_sample_reg, res_sample_next;

    // output register
    logic [23:0] m_sample_reg, m_sample_next;
    logic [13:0] m_red_reg, m_red_next;
    logic        m_chan_reg, m_chan_next;

    // shared units
    logic [pcrs_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic [pcrs_pkg::PROD_W-1:0] prod;
    logic [pcrs_pkg::ENV_W-1:0]  env_rd;
    logic                        env_wr_en;
    logic                        div_start;
    logic                        div_done;
    logic [30:0]                 div_t;
    logic [30:0]                 exp_res;

    logic [2:0]  sel_eff;
    logic        all_mode;
    logic [23:0] ea_frac;
    logic [11:0] ea_int;

    assign sel_eff  = (sel_reg > pcrs_pkg::SEL_ALL) ? pcrs_pkg::SEL_ALL : sel_reg;
    assign all_mode = (sel_eff == pcrs_pkg::SEL_ALL);
    assign ea_frac  = ea_reg[23:0];
    assign ea_int   = ea_reg[35:24];

    // finish exp2: integer part of the exponent as a right shift
    assign exp_res = (ea_int >= 12'd31) ? 31'd0 : 31'(m_reg >> ea_int[4:0]);

    pcrs_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    pcrs_env_mem u_env_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (pcrs_pkg::ENV_AW'(chan_reg)),
        .rd_data (env_rd),
        .wr_en   (env_wr_en),
        .wr_addr (pcrs_pkg::ENV_AW'(chan_reg)),
        .wr_data (env_next)
    );

    pcrs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .q     (exp_res),
        .done  (div_done),
        .t     (div_t)
    );

    always_comb
    begin
        logic [63:0] sum_v;
        logic [31:0] x32;
        logic [31:0] norm_v;
        logic [4:0]  shift_v;
        logic [4:0]  amt;
        logic        top_zero;
        logic [31:0] sq;
        logic [23:0] db;
        logic [16:0] rr;
        logic [26:0] o;

        sum_v    = '0;
        x32      = 32'(x_reg);
        norm_v   = norm_reg;
        shift_v  = shift_reg;
        amt      = 5'd1;
        top_zero = 1'b0;
        sq       = '0;
        db       = '0;
        rr       = '0;
        o        = '0;

        state_next      = state_reg;
        m_valid_next    = m_valid_reg;
        cnt_next        = cnt_reg;
        ph_next         = ph_reg;
        exp_clip_next   = exp_clip_reg;
        ig_next         = ig_reg;
        og_next         = og_reg;
        atk_next        = atk_reg;
        rel_next        = rel_reg;
        sel_next        = sel_reg;
        byp_next        = byp_reg;
        chan_next       = chan_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        x_next          = x_reg;
        env_next        = env_reg;
        diff_next       = diff_reg;
        rise_next       = rise_reg;
        norm_next       = norm_reg;
        shift_next      = shift_reg;
        p_next          = p_reg;
        frac_next       = frac_reg;
        m_next          = m_reg;
        over_next       = over_reg;
        red_next        = red_reg;
        red_db_next     = red_db_reg;
        ea_next         = ea_reg;
        gain_next       = gain_reg;
        y_next          = y_reg;
        t_next          = t_reg;
        clip_next       = clip_reg;
        res_sample_next = res_sample_reg;
        m_sample_next   = m_sample_reg;
        m_red_next      = m_red_reg;
        m_chan_next     = m_chan_reg;

        mul_a     = '0;
        mul_b     = '0;
        env_wr_en = 1'b0;
        div_start = 1'b0;

        // configuration writes; indexes past the list are dropped
        if (cfg_valid)
        begin
            unique case (pcrs_pkg::cfg_idx_t'(cfg_index))
                pcrs_pkg::CFG_INPUT_GAIN:    ig_next  = cfg_data[20:0];
                pcrs_pkg::CFG_OUTPUT_GAIN:   og_next  = cfg_data[20:0];
                pcrs_pkg::CFG_ATTACK_COEFF:  atk_next = cfg_data;
                pcrs_pkg::CFG_RELEASE_COEFF: rel_next = cfg_data;
                pcrs_pkg::CFG_RATIO_SELECT:  sel_next = cfg_data[2:0];
                pcrs_pkg::CFG_BYPASS:        byp_next = cfg_data[0];
                default:                     ;
            endcase
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            pcrs_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    chan_next = s_tuser[0];
                    neg_next  = s_tdata[23];
                    mag_next  = s_tdata[23] ? (~s_tdata + 24'd1) : s_tdata;
                    if (byp_reg || (int'(s_tuser) >= pcrs_pkg::CHANNELS))
                    begin
                        // pass through untouched, envelope held
                        res_sample_next = s_tdata;
                        red_db_next     = '0;
                        state_next      = pcrs_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = pcrs_pkg::ST_X_MUL;
                    end
                end
            end
            pcrs_pkg::ST_X_MUL:
            begin
                // envelope read issued here too, data arrives next cycle
                mul_a      = 32'(mag_reg);
                mul_b      = 32'(ig_reg);
                state_next = pcrs_pkg::ST_X_GET;
            end
            pcrs_pkg::ST_X_GET:
            begin
                sum_v      = prod + 64'd32768;
                x_next     = sum_v[43:16];
                env_next   = env_rd;
                state_next = pcrs_pkg::ST_ENV_DIF;
            end
            pcrs_pkg::ST_ENV_DIF:
            begin
                rise_next  = x32 > env_reg;
                diff_next  = (x32 > env_reg) ? x32 - env_reg : env_reg - x32;
                state_next = pcrs_pkg::ST_ENV_MUL;
            end
            pcrs_pkg::ST_ENV_MUL:
            begin
                mul_a      = 32'(rise_reg ? atk_reg : rel_reg);
                mul_b      = diff_reg;
                state_next = pcrs_pkg::ST_ENV_UPD;
            end
            pcrs_pkg::ST_ENV_UPD:
            begin
                // write back the new envelope; one item in flight, no overlap
                sum_v      = prod + (64'd1 << 23);
                env_next   = rise_reg ? env_reg + sum_v[55:24] : env_reg - sum_v[55:24];
                env_wr_en  = 1'b1;
                norm_next  = env_next;
                shift_next = '0;
                cnt_next   = '0;
                if (env_next == '0)
                begin
                    red_next    = '0;
                    red_db_next = '0;
                    state_next  = pcrs_pkg::ST_GEXP_MUL;
                end
                else
                begin
                    state_next = pcrs_pkg::ST_NORM;
                end
            end
            pcrs_pkg::ST_NORM:
            begin
                // leading-one search: 16, 8, 4, 2, 1 bit steps
                unique case (cnt_reg[2:0])
                    3'd0:
                    begin
                        top_zero = norm_reg[31:16] == '0;
                        amt      = 5'd16;
                    end
                    3'd1:
                    begin
                        top_zero = norm_reg[31:24] == '0;
                        amt      = 5'd8;
                    end
                    3'd2:
                    begin
                        top_zero = norm_reg[31:28] == '0;
                        amt      = 5'd4;
                    end
                    3'd3:
                    begin
                        top_zero = norm_reg[31:30] == '0;
                        amt      = 5'd2;
                    end
                    default:
                    begin
                        top_zero = !norm_reg[31];
                        amt      = 5'd1;
                    end
                endcase
                if (top_zero)
                begin
                    norm_v  = norm_reg << amt;
                    shift_v = shift_reg + amt;
                end
                norm_next  = norm_v;
                shift_next = shift_v;
                if (cnt_reg == 5'd4)
                begin
                    p_next     = 5'd31 - shift_v;
                    m_next     = {1'b0, norm_v[31:1]};
                    frac_next  = '0;
                    cnt_next   = '0;
                    ph_next    = 1'b0;
                    state_next = pcrs_pkg::ST_SQ;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            pcrs_pkg::ST_SQ:
            begin
                // one log2 fraction bit per squaring of the Q1.30 mantissa
                if (!ph_reg)
                begin
                    mul_a   = m_reg;
                    mul_b   = m_reg;
                    ph_next = 1'b1;
                end
                else
                begin
                    sq        = prod[61:30];
                    m_next    = sq[31] ? {1'b0, sq[31:1]} : sq;
                    frac_next = {frac_reg[14:0], sq[31]};
                    ph_next   = 1'b0;
                    if (cnt_reg == 5'd15)
                    begin
                        state_next = pcrs_pkg::ST_DB_MUL;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 5'd1;
                    end
                end
            end
            pcrs_pkg::ST_DB_MUL:
            begin
                mul_a      = 32'({p_reg, frac_reg});
                mul_b      = 32'(pcrs_pkg::DB_SCALE);
                state_next = pcrs_pkg::ST_DB_GET;
            end
            pcrs_pkg::ST_DB_GET:
            begin
                db         = prod[43:20];
                over_next  = (db > pcrs_pkg::DB_OFFSET) ? db - pcrs_pkg::DB_OFFSET : '0;
                state_next = pcrs_pkg::ST_RED_MUL;
            end
            pcrs_pkg::ST_RED_MUL:
            begin
                mul_a      = 32'(over_reg);
                mul_b      = 32'(pcrs_pkg::ratio_factor(sel_eff));
                state_next = pcrs_pkg::ST_RED_GET;
            end
            pcrs_pkg::ST_RED_GET:
            begin
                sum_v       = prod + 64'd32768;
                red_next    = sum_v[39:16];
                rr          = 17'(sum_v[39:24]) + 17'(sum_v[23]);
                red_db_next = (rr > 17'(pcrs_pkg::RED_MAX)) ? pcrs_pkg::RED_MAX : rr[13:0];
                state_next  = pcrs_pkg::ST_GEXP_MUL;
            end
            pcrs_pkg::ST_GEXP_MUL:
            begin
                mul_a      = 32'(red_reg);
                mul_b      = 32'(pcrs_pkg::RED_TO_EXP);
                state_next = pcrs_pkg::ST_GEXP_GET;
            end
            pcrs_pkg::ST_GEXP_GET:
            begin
                ea_next       = 36'(prod[45:16]);
                m_next        = pcrs_pkg::Q30_ONE;
                cnt_next      = '0;
                ph_next       = 1'b0;
                exp_clip_next = 1'b0;
                state_next    = pcrs_pkg::ST_EXP;
            end
            pcrs_pkg::ST_EXP:
            begin
                // multiply by 2^(-2^-k) for each set fraction bit, skip clear ones
                if (!ph_reg)
                begin
                    if (ea_frac[5'd23 - cnt_reg])
                    begin
                        mul_a   = m_reg;
                        mul_b   = 32'(pcrs_pkg::ROOT_TAB[cnt_reg]);
                        ph_next = 1'b1;
                    end
                    else if (cnt_reg == 5'd23)
                    begin
                        state_next = pcrs_pkg::ST_EXP_END;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 5'd1;
                    end
                end
                else
                begin
                    sum_v   = prod + (64'd1 << 29);
                    m_next  = sum_v[61:30];
                    ph_next = 1'b0;
                    if (cnt_reg == 5'd23)
                    begin
                        state_next = pcrs_pkg::ST_EXP_END;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 5'd1;
                    end
                end
            end
            pcrs_pkg::ST_EXP_END:
            begin
                if (exp_clip_reg)
                begin
                    div_start  = 1'b1;
                    state_next = pcrs_pkg::ST_DIV;
                end
                else
                begin
                    gain_next  = exp_res;
                    state_next = pcrs_pkg::ST_Y_MUL;
                end
            end
            pcrs_pkg::ST_Y_MUL:
            begin
                mul_a      = 32'(x_reg);
                mul_b      = 32'(gain_reg);
                state_next = pcrs_pkg::ST_Y_GET;
            end
            pcrs_pkg::ST_Y_GET:
            begin
                sum_v      = prod + (64'd1 << 29);
                y_next     = sum_v[57:30];
                state_next = pcrs_pkg::ST_A_MUL;
            end
            pcrs_pkg::ST_A_MUL:
            begin
                mul_a      = 32'(y_reg);
                mul_b      = 32'(all_mode ? pcrs_pkg::K_ALL : pcrs_pkg::K_STD);
                state_next = pcrs_pkg::ST_A_GET;
            end
            pcrs_pkg::ST_A_GET:
            begin
                sum_v         = prod + 64'd32768;
                ea_next       = sum_v[51:16];
                m_next        = pcrs_pkg::Q30_ONE;
                cnt_next      = '0;
                ph_next       = 1'b0;
                exp_clip_next = 1'b1;
                state_next    = pcrs_pkg::ST_EXP;
            end
            pcrs_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    t_next     = div_t;
                    state_next = pcrs_pkg::ST_T_MUL;
                end
            end
            pcrs_pkg::ST_T_MUL:
            begin
                mul_a      = 32'(t_reg);
                mul_b      = 32'(all_mode ? pcrs_pkg::N_ALL : pcrs_pkg::N_STD);
                state_next = pcrs_pkg::ST_T_GET;
            end
            pcrs_pkg::ST_T_GET:
            begin
                sum_v      = prod + (64'd1 << 29);
                clip_next  = sum_v[51:30];
                state_next = pcrs_pkg::ST_O_MUL;
            end
            pcrs_pkg::ST_O_MUL:
            begin
                mul_a      = 32'(clip_reg);
                mul_b      = 32'(og_reg);
                state_next = pcrs_pkg::ST_O_GET;
            end
            pcrs_pkg::ST_O_GET:
            begin
                // saturate the magnitude, then restore the sign
                sum_v = prod + 64'd32768;
                o     = sum_v[42:16];
                if (neg_reg)
                begin
                    res_sample_next = (o > pcrs_pkg::NEG_MAX) ? 24'h800000
                                                              : (~o[23:0] + 24'd1);
                end
                else
                begin
                    res_sample_next = (o > 27'(pcrs_pkg::POS_MAX)) ? pcrs_pkg::POS_MAX
                                                                   : o[23:0];
                end
                state_next = pcrs_pkg::ST_DONE;
            end
            pcrs_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_sample_next = res_sample_reg;
                    m_red_next    = red_db_reg;
                    m_chan_next   = chan_reg;
                    state_next    = pcrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pcrs_pkg::ST_IDLE;
            m_valid_reg  <= 1'b0;
            cnt_reg      <= '0;
            ph_reg       <= 1'b0;
            exp_clip_reg <= 1'b0;
            ig_reg       <= pcrs_pkg::INPUT_GAIN_RST;
            og_reg       <= pcrs_pkg::OUTPUT_GAIN_RST;
            atk_reg      <= pcrs_pkg::ATTACK_COEFF_RST;
            rel_reg      <= pcrs_pkg::RELEASE_COEFF_RST;
            sel_reg      <= pcrs_pkg::RATIO_SELECT_RST;
            byp_reg      <= pcrs_pkg::BYPASS_RST;
        end
        else
        begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            cnt_reg      <= cnt_next;
            ph_reg       <= ph_next;
            exp_clip_reg <= exp_clip_next;
            ig_reg       <= ig_next;
            og_reg       <= og_next;
            atk_reg      <= atk_next;
            rel_reg      <= rel_next;
            sel_reg      <= sel_next;
            byp_reg      <= byp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chan_reg       <= chan_next;
        neg_reg        <= neg_next;
        mag_reg        <= mag_next;
        x_reg          <= x_next;
        env_reg        <= env_next;
        diff_reg       <= diff_next;
        rise_reg       <= rise_next;
        norm_reg       <= norm_next;
        shift_reg      <= shift_next;
        p_reg          <= p_next;
        frac_reg       <= frac_next;
        m_reg          <= m_next;
        over_reg       <= over_next;
        red_reg        <= red_next;
        red_db_reg     <= red_db_next;
        ea_reg         <= ea_next;
        gain_reg       <= gain_next;
        y_reg          <= y_next;
        t_reg          <= t_next;
        clip_reg       <= clip_next;
        res_sample_reg <= res_sample_next;
        m_sample_reg   <= m_sample_next;
        m_red_reg      <= m_red_next;
        m_chan_reg     <= m_chan_next;
    end

    assign s_tready  = (state_reg == pcrs_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {2'b00, m_red_reg, m_sample_reg};
    assign m_tuser   = m_chan_reg;

endmodule

### sv/pcrs_chk.sv
// Port-level checker for the compressor, bound to the top level.
module pcrs_chk
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pcrs_pkg::OUT_DATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output word changed while stalled");

    // one word in process at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is in process");

    // a new result is posted as the sequencer returns to idle
    a_post_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result posted while sequencer busy");

endmodule

bind peak_compressor_ratio_select pcrs_chk u_pcrs_chk (.*);

### sim/peak_compressor_ratio_select_test.sv
// Self-checking testbench for the peak compressor with ratio select.
`timescale 1ns / 100ps

module peak_compressor_ratio_select_test;

    // bench timing
    localparam int  HALF_HI     = 6;
    localparam int  HALF_LO     = 6;
    localparam int  RESET_LEN   = 8;
    localparam int  DRAIN_WAIT  = 400;
    localparam longint CYCLE_LIMIT = 2_000_000;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [23:0]                     s_tdata;     // [23:0] sample_in
    logic [0:0]                      s_tuser;     // [0] channel
    logic                            m_tvalid;
    logic                            m_tready;
    logic [pcrs_pkg::OUT_DATA_W-1:0] m_tdata;     // [23:0] sample_out, [37:24] reduction_db
    logic [0:0]                      m_tuser;     // [0] channel_out
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [pcrs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pcrs_pkg::CFG_DATA_W-1:0] cfg_data;

    peak_compressor_ratio_select u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // one expected output word
    typedef struct packed {
        logic [23:0] sample;
        logic        chan;
        logic [13:0] red_db;
    } comp_word_t;

    comp_word_t  comp_expected[$];
    int          fail_count = 0;
    longint      cycle_count = 0;
    bit          idle_enable;   // random gaps on both streams when set

    // predictor state: shadow registers and per-channel envelope
    logic [20:0] pr_in_gain;
    logic [20:0] pr_out_gain;
    logic [23:0] pr_attack;
    logic [23:0] pr_release;
    logic [2:0]  pr_ratio;
    logic        pr_bypass;
    logic [31:0] pr_env[pcrs_pkg::CHANNELS];
    logic [63:0] halving_root[24];

    // clock with separate high and low phases
    initial clk = 1'b0;
    always
    begin
        #HALF_LO clk = 1'b1;
        #HALF_HI clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // square-root chain 2^(-2^-k) in Q0.30, built here independently
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 0;
        hi = 64'd4294967296;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    // 2^(-a) in Q0.30 for a in Q.24
    function automatic logic [63:0] pow2_neg(input logic [63:0] a);
        logic [63:0] m;
        int          k;
        m = 64'd1 << 30;
        if ((a >> 24) >= 31) return 0;
        for (k = 1; k <= 24; k++)
            if (a[24-k])
                m = (m * halving_root[k-1] + (64'd1 << 29)) >> 30;
        return m >> (a >> 24);
    endfunction

    // log2(e) in Q.16, truncating squaring of the mantissa
    function automatic logic [63:0] log2_q16(input logic [31:0] e);
        logic [63:0] m;
        logic [63:0] frac;
        int          p;
        int          i;
        frac = 0;
        p = 31;
        while (p > 0 && !e[p]) p--;
        m = (p <= 30) ? (64'(e) << (30 - p)) : (64'(e) >> (p - 30));
        for (i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (64'(p) << 16) + frac;
    endfunction

    // compress one sample, update the envelope unless bypassed, return the expected word
    function automatic comp_word_t compress_sample(input logic [23:0] s, input logic ch);
        comp_word_t  w;
        logic        neg;
        logic [63:0] mag, x, env, red, db, o, gain, y, a, q, t, clip;
        logic [2:0]  sel;
        logic [63:0] one;
        one = 64'd1 << 30;
        w.chan = ch;
        red = 0;
        if (pr_bypass)
        begin
            w.sample = s;
            w.red_db = '0;
            return w;
        end
        neg = s[23];
        mag = neg ? ((64'd1 << 24) - 64'(s)) : 64'(s);
        x = (mag * pr_in_gain + (64'd1 << 15)) >> 16;
        env = 64'(pr_env[ch]);
        if (x > env)
            env = env + ((64'(pr_attack) * (x - env) + (64'd1 << 23)) >> 24);
        else
            env = env - ((64'(pr_release) * (env - x) + (64'd1 << 23)) >> 24);
        pr_env[ch] = env[31:0];
        sel = (pr_ratio > pcrs_pkg::SEL_ALL) ? pcrs_pkg::SEL_ALL : pr_ratio;
        if (env != 0)
        begin
            db = (log2_q16(env[31:0]) * 64'd6313057) >> 20;
            if (db > 64'd6318457)
                red = ((db - 64'd6318457) * pcrs_pkg::ratio_factor(sel) + 64'd32768) >> 16;
        end
        o = (red + 128) >> 8;
        w.red_db = (o > 16383) ? 14'd16383 : o[13:0];
        gain = pow2_neg((red * 64'd2786635) >> 16);
        y = (x * gain + (64'd1 << 29)) >> 30;
        a = (y * ((sel == pcrs_pkg::SEL_ALL) ? 64'd4387049 : 64'd3479383) + 64'd32768) >> 16;
        q = pow2_neg(a);
        t = ((one - q) << 30) / (one + q);
        clip = (t * ((sel == pcrs_pkg::SEL_ALL) ? 64'd1170687 : 64'd1282264)
                + (64'd1 << 29)) >> 30;
        o = (clip * pr_out_gain + 64'd32768) >> 16;
        if (neg)
        begin
            if (o > 64'd8388608) o = 64'd8388608;
            w.sample = 24'((64'd1 << 24) - o);
        end
        else
        begin
            if (o > 64'd8388607) o = 64'd8388607;
            w.sample = o[23:0];
        end
        return w;
    endfunction

    // random gap unless idling is switched off; drop valid while idle
    task automatic idle_gap();
        while (idle_enable && $urandom_range(99) < 16)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // send one sample word and queue its expected result on acceptance
    task automatic send_sample(input logic [23:0] s, input logic ch);
        comp_word_t w;
        idle_gap();
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        s_tuser  <= ch;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        w = compress_sample(s, ch);
        comp_expected.insert(comp_expected.size(), w);
    endtask

    // wait for the pipeline to empty, then leave room for the block to settle
    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (comp_expected.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // write one register while idle and mirror it in the predictor
    task automatic write_reg(input pcrs_pkg::cfg_idx_t idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            pcrs_pkg::CFG_INPUT_GAIN:    pr_in_gain  = val[20:0];
            pcrs_pkg::CFG_OUTPUT_GAIN:   pr_out_gain = val[20:0];
            pcrs_pkg::CFG_ATTACK_COEFF:  pr_attack   = val;
            pcrs_pkg::CFG_RELEASE_COEFF: pr_release  = val;
            pcrs_pkg::CFG_RATIO_SELECT:  pr_ratio    = val[2:0];
            pcrs_pkg::CFG_BYPASS:        pr_bypass   = val[0];
            default: ;
        endcase
    endtask

    // check each output word against the oldest expectation
    always @(posedge clk)
    begin
        comp_word_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (comp_expected.size() == 0)
            begin
                $display("%0t: unexpected word expected none actual %h", $time, m_tdata);
                fail_count++;
            end
            else
            begin
                w = comp_expected.pop_front();
                if (m_tdata[23:0] !== w.sample)
                begin
                    $display("%0t: sample_out expected %h actual %h",
                             $time, w.sample, m_tdata[23:0]);
                    fail_count++;
                end
                if (m_tdata[37:24] !== w.red_db)
                begin
                    $display("%0t: reduction_db expected %h actual %h",
                             $time, w.red_db, m_tdata[37:24]);
                    fail_count++;
                end
                if (m_tuser[0] !== w.chan)
                begin
                    $display("%0t: channel_out expected %b actual %b",
                             $time, w.chan, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk)
        m_tready <= idle_enable ? ($urandom_range(99) >= 16) : 1'b1;

    // bypass: words pass unchanged, no reduction, envelope untouched
    task automatic test_bypass();
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h800000, 1'b1);
        send_sample(24'h000000, 1'b0);
        send_sample(24'hFFFFFF, 1'b1);
        repeat (8) send_sample(24'($urandom), 1'($urandom));
        drain();
    endtask

    // field extremes with each ratio, incl. all-ratio drive and selects 5..7
    task automatic test_extremes();
        int r;
        write_reg(pcrs_pkg::CFG_BYPASS, 24'd0);
        for (r = 0; r < 8; r++)
        begin
            write_reg(pcrs_pkg::CFG_RATIO_SELECT, 24'(r));
            send_sample(24'h000000, 1'b0);           // zero sample; zero envelope at r = 0
            send_sample(24'h7FFFFF, 1'b0);
            send_sample(24'h800000, 1'b1);
            drain();
        end
        // maximum gains and coefficients to push saturation
        write_reg(pcrs_pkg::CFG_INPUT_GAIN, 24'h1FFFFF);
        write_reg(pcrs_pkg::CFG_OUTPUT_GAIN, 24'h1FFFFF);
        write_reg(pcrs_pkg::CFG_ATTACK_COEFF, 24'hFFFFFF);
        write_reg(pcrs_pkg::CFG_RELEASE_COEFF, 24'hFFFFFF);
        write_reg(pcrs_pkg::CFG_RATIO_SELECT, 24'(pcrs_pkg::SEL_ALL));
        send_sample(24'h800000, 1'b0);
        send_sample(24'h7FFFFF, 1'b1);
        send_sample(24'h000001, 1'b0);
        drain();
        // zero gains and coefficients
        write_reg(pcrs_pkg::CFG_INPUT_GAIN, 24'd0);
        write_reg(pcrs_pkg::CFG_OUTPUT_GAIN, 24'd0);
        write_reg(pcrs_pkg::CFG_ATTACK_COEFF, 24'd0);
        write_reg(pcrs_pkg::CFG_RELEASE_COEFF, 24'd0);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h800000, 1'b1);
        drain();
    endtask

    // random phases: each picks a setting, then bursts of audio-like words
    task automatic test_random(input int phases, input int per_phase);
        int p;
        int i;
        logic [23:0] s;
        for (p = 0; p < phases; p++)
        begin
            idle_enable = (p != 2);    // one long stretch without gaps
            write_reg(pcrs_pkg::CFG_INPUT_GAIN,
                      24'($urandom_range(3) == 0 ? $urandom : $urandom_range(131072)));
            write_reg(pcrs_pkg::CFG_OUTPUT_GAIN,
                      24'($urandom_range(3) == 0 ? $urandom : $urandom_range(131072)));
            write_reg(pcrs_pkg::CFG_ATTACK_COEFF,
                      $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(400000)));
            write_reg(pcrs_pkg::CFG_RELEASE_COEFF,
                      $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(20000)));
            write_reg(pcrs_pkg::CFG_RATIO_SELECT, 24'($urandom_range(7)));
            write_reg(pcrs_pkg::CFG_BYPASS, 24'($urandom_range(9) == 0));
            for (i = 0; i < per_phase; i++)
            begin
                case ($urandom_range(3))
                    0:       s = 24'($urandom);
                    1:       s = 24'($signed($urandom_range(65535)) - 32768);
                    2:       s = $urandom_range(1) ? 24'h7FFFFF - 24'($urandom_range(255))
                                                   : 24'h800000 + 24'($urandom_range(255));
                    default: s = 24'($signed($urandom_range(2097151)) - 1048576);
                endcase
                send_sample(s, 1'($urandom));
            end
            drain();
        end
    endtask

    initial
    begin
        int k;
        idle_enable = 1'b1;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = pcrs_pkg::CFG_INPUT_GAIN;
        cfg_data  = '0;
        pr_in_gain  = pcrs_pkg::INPUT_GAIN_RST;
        pr_out_gain = pcrs_pkg::OUTPUT_GAIN_RST;
        pr_attack   = pcrs_pkg::ATTACK_COEFF_RST;
        pr_release  = pcrs_pkg::RELEASE_COEFF_RST;
        pr_ratio    = pcrs_pkg::RATIO_SELECT_RST;
        pr_bypass   = pcrs_pkg::BYPASS_RST;
        for (k = 0; k < pcrs_pkg::CHANNELS; k++) pr_env[k] = '0;
        halving_root[0] = int_sqrt(64'd1 << 59);
        for (k = 1; k < 24; k++) halving_root[k] = int_sqrt(halving_root[k-1] << 30);

        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bypass();
        test_extremes();
        test_random(12, 75);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
